// ===== src/mtep_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mtep_pkg
// types and constants shared by the midi track event parser
// ----------------------------------------------------------------------------
package mtep_pkg;

   localparam logic [7:0] STATUS_BIT  = 8'h80;
   localparam logic [7:0] DATA_MASK   = 8'h7F;
   localparam logic [7:0] TYPE_MASK   = 8'hF0;
   localparam logic [7:0] SYSEX_START = 8'hF0;
   localparam logic [7:0] SYSEX_END   = 8'hF7;
   localparam logic [7:0] META_STATUS = 8'hFF;
   localparam logic [7:0] PROG_CHANGE = 8'hC0;
   localparam logic [7:0] CHAN_PRESS  = 8'hD0;
   localparam logic [2:0] VARLEN_MAX  = 3'd4;

   localparam int TICK_W = 32;
   localparam int LEN_W  = 28;

   typedef enum logic [2:0] {
      PH_DELTA  = 3'd0,
      PH_STATUS = 3'd1,
      PH_META   = 3'd2,
      PH_LEN    = 3'd3,
      PH_PAY    = 3'd4,
      PH_D1     = 3'd5,
      PH_D2     = 3'd6,
      PH_HALT   = 3'd7
   } phase_type;

   typedef enum logic [1:0] {
      KIND_CHANNEL = 2'd0,
      KIND_HEADER  = 2'd1,
      KIND_PAYLOAD = 2'd2,
      KIND_ERROR   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE   = 2'd0,
      ERR_VARLEN = 2'd1,
      ERR_TRUNC  = 2'd2
   } err_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_of_track;
      logic       last_of_track;
   } item_type;

   typedef struct packed {
      kind_type          kind;
      logic [TICK_W-1:0] tick;
      logic [7:0]        status;
      logic [7:0]        data_first;
      logic [7:0]        data_second;
      logic [7:0]        meta_kind;
      logic [LEN_W-1:0]  payload_length;
      logic [7:0]        payload_byte;
      logic              last_of_event;
      err_type           error_code;
   } result_type;

endpackage
`default_nettype wire

// ===== src/mtep_chan_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mtep channel interfaces
// valid/ready channels for track bytes in and parsed events out
// ----------------------------------------------------------------------------
interface mtep_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first_of_track;
   logic       last_of_track;

   modport source (output valid, data_byte, first_of_track, last_of_track, input ready);
   modport sink   (input valid, data_byte, first_of_track, last_of_track, output ready);
endinterface

interface mtep_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [31:0] tick;
   logic [7:0]  status;
   logic [7:0]  data_first;
   logic [7:0]  data_second;
   logic [7:0]  meta_kind;
   logic [27:0] payload_length;
   logic [7:0]  payload_byte;
   logic        last_of_event;
   logic [1:0]  error_code;

   modport source (output valid, kind, tick, status, data_first, data_second, meta_kind,
                   payload_length, payload_byte, last_of_event, error_code, input ready);
   modport sink   (input valid, kind, tick, status, data_first, data_second, meta_kind,
                   payload_length, payload_byte, last_of_event, error_code, output ready);
endinterface
`default_nettype wire

// ===== src/mtep_in_reg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mtep_in_reg
// input register holding one track byte until the parser takes it
// ----------------------------------------------------------------------------
module mtep_in_reg (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output      logic              in_ready,
   input  wire mtep_pkg::item_type in_item,
   input  wire logic              advance,
   output      logic              item_valid,
   output      mtep_pkg::item_type item
);

   logic               valid_ff, valid_in;
   mtep_pkg::item_type item_ff;

   assign in_ready   = !valid_ff || advance;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

endmodule
`default_nettype wire

// ===== src/mtep_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mtep_parser
// per-byte parse step: delta time, status, meta type, length, payload, data
// ----------------------------------------------------------------------------
module mtep_parser (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                fire,
   input  wire mtep_pkg::item_type  item,
   output      logic                res_valid,
   output      mtep_pkg::result_type res
);

   localparam int TW = mtep_pkg::TICK_W;
   localparam int LW = mtep_pkg::LEN_W;

   mtep_pkg::phase_type phase_ff, phase_in;
   logic [TW-1:0]       tick_ff, tick_in;
   logic [7:0]          run_ff, run_in;
   logic [7:0]          cur_ff, cur_in;
   logic [LW-1:0]       acc_ff, acc_in;
   logic [2:0]          cnt_ff, cnt_in;
   logic [7:0]          first_ff, first_in;
   logic [7:0]          meta_ff, meta_in;
   logic [LW-1:0]       left_ff, left_in;

   always_comb begin
      logic [7:0]          b;
      mtep_pkg::phase_type ph;
      logic [LW-1:0]       acc_v;
      logic [2:0]          cnt_v;
      logic                vl_done, vl_long;
      logic                len_go, d1_go, err1, err2, emit;
      logic [7:0]          d1_type;

      b = item.data_byte;
      ph = phase_ff;
      tick_in  = tick_ff;
      run_in   = run_ff;
      cur_in   = cur_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      first_in = first_ff;
      meta_in  = meta_ff;
      left_in  = left_ff;
      if (item.first_of_track) begin
         ph = mtep_pkg::PH_DELTA;
         tick_in  = '0;
         run_in   = '0;
         cur_in   = '0;
         acc_in   = '0;
         cnt_in   = '0;
         first_in = '0;
         meta_in  = '0;
         left_in  = '0;
      end
      phase_in = ph;

      acc_v   = {acc_in[LW-8:0], b[6:0]};
      cnt_v   = cnt_in + 3'd1;
      vl_done = (b & mtep_pkg::STATUS_BIT) == 8'h00;
      vl_long = !vl_done && (cnt_v >= mtep_pkg::VARLEN_MAX);

      len_go  = 1'b0;
      d1_go   = 1'b0;
      d1_type = '0;
      err1    = 1'b0;
      err2    = 1'b0;
      emit    = 1'b0;
      res     = '0;

      case (ph)
         mtep_pkg::PH_DELTA: begin
            if (vl_done) begin
               tick_in  = tick_in + {{(TW-LW){1'b0}}, acc_v};
               acc_in   = '0;
               cnt_in   = '0;
               phase_in = mtep_pkg::PH_STATUS;
            end else if (vl_long) begin
               err1 = 1'b1;
            end else begin
               acc_in = acc_v;
               cnt_in = cnt_v;
            end
         end
         mtep_pkg::PH_STATUS: begin
            meta_in = '0;
            if (!vl_done) begin
               cur_in = b;
               if (b != mtep_pkg::SYSEX_START && b != mtep_pkg::META_STATUS) begin
                  run_in = b;
               end
               if (b == mtep_pkg::META_STATUS) begin
                  phase_in = mtep_pkg::PH_META;
               end else if (b == mtep_pkg::SYSEX_START || b == mtep_pkg::SYSEX_END) begin
                  phase_in = mtep_pkg::PH_LEN;
               end else begin
                  phase_in = mtep_pkg::PH_D1;
               end
            end else begin
               cur_in = run_in;
               if (run_in == mtep_pkg::SYSEX_END) begin
                  phase_in = mtep_pkg::PH_LEN;
                  len_go   = 1'b1;
               end else begin
                  d1_go   = 1'b1;
                  d1_type = run_in & mtep_pkg::TYPE_MASK;
               end
            end
         end
         mtep_pkg::PH_META: begin
            meta_in  = b;
            phase_in = mtep_pkg::PH_LEN;
         end
         mtep_pkg::PH_LEN: begin
            len_go = 1'b1;
         end
         mtep_pkg::PH_PAY: begin
            left_in           = left_in - {{(LW-1){1'b0}}, 1'b1};
            emit              = 1'b1;
            res.kind          = mtep_pkg::KIND_PAYLOAD;
            res.payload_byte  = b;
            res.last_of_event = (left_in == '0);
            if (left_in == '0) begin
               phase_in = mtep_pkg::PH_DELTA;
            end
         end
         mtep_pkg::PH_D1: begin
            d1_go   = 1'b1;
            d1_type = cur_in & mtep_pkg::TYPE_MASK;
         end
         mtep_pkg::PH_D2: begin
            emit              = 1'b1;
            res.kind          = mtep_pkg::KIND_CHANNEL;
            res.data_first    = first_in;
            res.data_second   = b;
            res.last_of_event = 1'b1;
            phase_in          = mtep_pkg::PH_DELTA;
         end
         mtep_pkg::PH_HALT: begin
         end
         default: begin
         end
      endcase

      if (len_go) begin
         if (vl_long) begin
            err1 = 1'b1;
         end else if (!vl_done) begin
            acc_in = acc_v;
            cnt_in = cnt_v;
         end else begin
            left_in            = acc_v;
            acc_in             = '0;
            cnt_in             = '0;
            emit               = 1'b1;
            res.kind           = mtep_pkg::KIND_HEADER;
            res.payload_length = acc_v;
            res.last_of_event  = (acc_v == '0);
            phase_in = (acc_v == '0) ? mtep_pkg::PH_DELTA : mtep_pkg::PH_PAY;
         end
      end

      if (d1_go) begin
         first_in = b;
         if (d1_type == mtep_pkg::PROG_CHANGE || d1_type == mtep_pkg::CHAN_PRESS) begin
            emit              = 1'b1;
            res.kind          = mtep_pkg::KIND_CHANNEL;
            res.data_first    = b;
            res.last_of_event = 1'b1;
            phase_in          = mtep_pkg::PH_DELTA;
         end else begin
            phase_in = mtep_pkg::PH_D2;
         end
      end

      if (err1) begin
         phase_in = mtep_pkg::PH_HALT;
         acc_in   = '0;
         cnt_in   = '0;
      end

      if (item.last_of_track) begin
         err2 = !err1 && phase_in != mtep_pkg::PH_HALT &&
                !(phase_in == mtep_pkg::PH_DELTA && cnt_in == '0);
         phase_in = mtep_pkg::PH_DELTA;
         acc_in   = '0;
         cnt_in   = '0;
         left_in  = '0;
      end

      if (err1 || err2) begin
         res               = '0;
         res.kind          = mtep_pkg::KIND_ERROR;
         res.last_of_event = 1'b1;
         res.error_code    = err1 ? mtep_pkg::ERR_VARLEN : mtep_pkg::ERR_TRUNC;
      end

      res.tick      = tick_in;
      res.status    = cur_in;
      res.meta_kind = (cur_in == mtep_pkg::META_STATUS) ? meta_in : 8'h00;
      res_valid     = emit || err1 || err2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= mtep_pkg::PH_DELTA;
         tick_ff  <= '0;
         run_ff   <= '0;
         cur_ff   <= '0;
         acc_ff   <= '0;
         cnt_ff   <= '0;
         first_ff <= '0;
         meta_ff  <= '0;
         left_ff  <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         run_ff   <= run_in;
         cur_ff   <= cur_in;
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         first_ff <= first_in;
         meta_ff  <= meta_in;
         left_ff  <= left_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/mtep_rsp_reg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mtep_rsp_reg
// result register; frees itself on an output transfer
// ----------------------------------------------------------------------------
module mtep_rsp_reg (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire mtep_pkg::result_type res,
   output      logic                 space,
   output      logic                 out_valid,
   input  wire logic                 out_ready,
   output      mtep_pkg::result_type out_res
);

   logic                 valid_ff, valid_in;
   mtep_pkg::result_type res_ff;

   assign space     = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_res   = res_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res;
      end
   end

endmodule
`default_nettype wire

// ===== src/midi_track_event_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// midi_track_event_parser
// streaming parser for the event stream of one midi track chunk
// ----------------------------------------------------------------------------
// registers: a byte is held in the input register, and its result in the result register
// throughput: one byte per cycle while the result register has space, set by the single parse step per byte
// bytes producing no result still pass through the parse step
// reset: synchronous; clears parse phase, tick, running status and both valid flags
// ----------------------------------------------------------------------------
module midi_track_event_parser (
   input wire logic  clock,
   input wire logic  reset,
   mtep_req_if.sink   req_chan,
   mtep_rsp_if.source rsp_chan
);

   mtep_pkg::item_type   req_item, item;
   mtep_pkg::result_type res, out_res;
   logic                 item_valid, advance, space, res_valid, load;

   assign req_item.data_byte      = req_chan.data_byte;
   assign req_item.first_of_track = req_chan.first_of_track;
   assign req_item.last_of_track  = req_chan.last_of_track;

   assign advance = item_valid && space;
   assign load    = advance && res_valid;

   mtep_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_chan.valid),
      .in_ready   (req_chan.ready),
      .in_item    (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   mtep_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .fire      (advance),
      .item      (item),
      .res_valid (res_valid),
      .res       (res)
   );

   mtep_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .res       (res),
      .space     (space),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_res   (out_res)
   );

   assign rsp_chan.kind           = out_res.kind;
   assign rsp_chan.tick           = out_res.tick;
   assign rsp_chan.status         = out_res.status;
   assign rsp_chan.data_first     = out_res.data_first;
   assign rsp_chan.data_second    = out_res.data_second;
   assign rsp_chan.meta_kind      = out_res.meta_kind;
   assign rsp_chan.payload_length = out_res.payload_length;
   assign rsp_chan.payload_byte   = out_res.payload_byte;
   assign rsp_chan.last_of_event  = out_res.last_of_event;
   assign rsp_chan.error_code     = out_res.error_code;

endmodule
`default_nettype wire

// ===== src/mtep_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mtep_checker
// port-level checks on the parsed event stream
// ----------------------------------------------------------------------------
module mtep_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_kind,
   input wire logic [31:0] rsp_tick,
   input wire logic [1:0]  rsp_error_code,
   input wire logic        rsp_last_of_event,
   input wire logic [7:0]  rsp_payload_byte
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tick) && $stable(rsp_kind))
      else $error("stalled result changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_kind == mtep_pkg::KIND_ERROR) == (rsp_error_code != 2'd0)))
      else $error("error code does not match kind");

   a_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == mtep_pkg::KIND_ERROR || rsp_kind == mtep_pkg::KIND_CHANNEL)
      |-> rsp_last_of_event)
      else $error("channel or error result does not close its event");

   a_payload_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != mtep_pkg::KIND_PAYLOAD |-> rsp_payload_byte == 8'h00)
      else $error("payload byte set outside a payload transfer");

endmodule

bind midi_track_event_parser mtep_checker u_mtep_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_kind           (rsp_chan.kind),
   .rsp_tick           (rsp_chan.tick),
   .rsp_error_code     (rsp_chan.error_code),
   .rsp_last_of_event  (rsp_chan.last_of_event),
   .rsp_payload_byte   (rsp_chan.payload_byte)
);
`default_nettype wire
